[sv/ble_pkg.sv]
// Shared types and constants of the battery level estimator.
package ble_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam int MV_W       = 16;
   localparam int PCT_W      = 7;
   localparam int GAIN_W     = 4;
   localparam int CAL_W      = 24;
   localparam int NUM_W      = 24;
   localparam int DEN_W      = 16;
   localparam int CNT_W      = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_FULL   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_EIGHTY = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_SIXTY  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_FORTY  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_TWENTY = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_EMPTY  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_GAIN = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VREF_CAL     = 4'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_B,
      ST_DIV_B,
      ST_LOAD_R,
      ST_DIV_R,
      ST_LOAD_S,
      ST_DIV_S,
      ST_LOAD_M,
      ST_MUL,
      ST_SAT,
      ST_SEL,
      ST_DIV_P,
      ST_FINISH
   } state_type;

endpackage

[sv/ble_if.sv]
// Valid/ready channel interfaces for samples, results and register writes.
interface ble_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] battery_sample;
   logic [SAMPLE_BITS-1:0] reference_sample;
   modport source (output valid, battery_sample, reference_sample, input ready);
   modport sink   (input valid, battery_sample, reference_sample, output ready);
endinterface

interface ble_rsp_if import ble_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             window_full;
   logic [MV_W-1:0]  battery_mv;
   logic [PCT_W-1:0] charge_percent;
   modport source (output valid, window_full, battery_mv, charge_percent, input ready);
   modport sink   (input valid, window_full, battery_mv, charge_percent, output ready);
endinterface

interface ble_csr_if import ble_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/battery_level_estimator.sv]
// Battery level estimator: sample window, supply and battery voltage, charge percent.

// Each accepted item is one pair of ADC samples (battery divider and internal
// reference). The pair goes into a WINDOW_LEN-entry window and running sums of
// both rings are kept up to date. The block then works on that one item alone:
// a bit-serial restoring divider (one quotient bit per cycle) forms the two
// window means and the supply voltage, a bit-serial shift-add multiplier
// forms the battery voltage, and a last divider pass interpolates the
// charge percentage inside its band. That last pass runs only when the
// voltage lies inside one of the interpolated bands. The next item is taken
// as soon as the result sits in the output register, so a slow consumer only
// stalls the block at the end of the following item. Register writes are
// accepted at any time and should only be issued while the block is idle.
module battery_level_estimator import ble_pkg::*; #(
   parameter int WINDOW_LEN  = 10,
   parameter int SAMPLE_BITS = 12
) (
   input  logic  clock,
   input  logic  reset,
   ble_req_if.sink   req_ch,
   ble_rsp_if.source rsp_ch,
   ble_csr_if.sink   csr_ch
);

   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W  = SAMPLE_BITS + 4;
   localparam int MCAND_W = SAMPLE_BITS + GAIN_W;
   localparam int PROD_W = MCAND_W + NUM_W;

   // Configuration registers.
   logic [MV_W-1:0]   level_ff [6];
   logic [GAIN_W-1:0] gain_ff;
   logic [CAL_W-1:0]  cal_ff;

   // Sample window and its running sums.
   logic [SAMPLE_BITS-1:0] bat_ring_ff [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] ref_ring_ff [WINDOW_LEN];
   logic [SUM_W-1:0]       bat_sum_ff, bat_sum_in;
   logic [SUM_W-1:0]       ref_sum_ff, ref_sum_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   filled_ff, filled_in;

   // Sequencer and serial datapath.
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] bmean_ff, bmean_in;
   logic [SAMPLE_BITS-1:0] rmean_ff, rmean_in;
   logic [MCAND_W-1:0]     mcand_ff, mcand_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [MV_W-1:0]        mv_ff, mv_in;
   logic [PCT_W-1:0]       base_ff, base_in;
   logic                   band_ff, band_in;
   logic                   zero_fix_ff, zero_fix_in;
   logic [PCT_W-1:0]       pct_ff, pct_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_full_ff, rsp_full_in;
   logic [MV_W-1:0]  rsp_mv_ff, rsp_mv_in;
   logic [PCT_W-1:0] rsp_pct_ff, rsp_pct_in;

   logic accept;
   logic div_last;
   logic out_free;
   logic [DEN_W:0]   div_trial;
   logic             div_take;
   logic [PCT_W-1:0] band_pct;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign div_last     = (cnt_ff == CNT_W'(NUM_W - 1));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.window_full    = rsp_full_ff;
   assign rsp_ch.battery_mv     = rsp_mv_ff;
   assign rsp_ch.charge_percent = rsp_pct_ff;

   // One restoring division step: shift in the next dividend bit and subtract
   // the divisor when it fits. The quotient bits shift into num_ff.
   assign div_trial = {rem_ff, num_ff[NUM_W-1]};
   assign div_take  = (div_trial >= {1'b0, den_ff});

   // Interpolated percentage; the lowest band reports 1 instead of 0.
   always_comb begin
      band_pct = base_ff + num_ff[PCT_W-1:0];
      if (zero_fix_ff && band_pct == '0) begin
         band_pct = PCT_W'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_LOAD_B;
         ST_LOAD_B: state_in = ST_DIV_B;
         ST_DIV_B:  if (div_last) state_in = ST_LOAD_R;
         ST_LOAD_R: state_in = ST_DIV_R;
         ST_DIV_R:  if (div_last) state_in = ST_LOAD_S;
         ST_LOAD_S: state_in = ST_DIV_S;
         ST_DIV_S:  if (div_last) state_in = ST_LOAD_M;
         ST_LOAD_M: state_in = ST_MUL;
         ST_MUL:    if (div_last) state_in = ST_SAT;
         ST_SAT:    state_in = ST_SEL;
         ST_SEL:    state_in = band_in ? ST_DIV_P : ST_FINISH;
         ST_DIV_P:  if (div_last) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath.
   always_comb begin
      logic [MV_W-1:0] lo;
      logic [MV_W-1:0] hi;
      logic [MV_W-1:0] diff;
      logic [20:0]     scaled;

      bat_sum_in  = bat_sum_ff;
      ref_sum_in  = ref_sum_ff;
      slot_in     = slot_ff;
      filled_in   = filled_ff;
      cnt_in      = cnt_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      bmean_in    = bmean_ff;
      rmean_in    = rmean_ff;
      mcand_in    = mcand_ff;
      acc_in      = acc_ff;
      mv_in       = mv_ff;
      base_in     = base_ff;
      band_in     = band_ff;
      zero_fix_in = zero_fix_ff;
      pct_in      = pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_full_in  = rsp_full_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      lo     = '0;
      hi     = '0;
      diff   = '0;
      scaled = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bat_sum_in = bat_sum_ff + SUM_W'(req_ch.battery_sample)
                            - SUM_W'(bat_ring_ff[slot_ff]);
               ref_sum_in = ref_sum_ff + SUM_W'(req_ch.reference_sample)
                            - SUM_W'(ref_ring_ff[slot_ff]);
               if (slot_ff == SLOT_W'(WINDOW_LEN - 1)) begin
                  slot_in   = '0;
                  filled_in = 1'b1;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         ST_LOAD_B: begin
            num_in = NUM_W'(bat_sum_ff);
            den_in = DEN_W'(WINDOW_LEN);
            rem_in = '0;
            cnt_in = '0;
         end
         ST_LOAD_R: begin
            bmean_in = num_ff[SAMPLE_BITS-1:0];
            num_in   = NUM_W'(ref_sum_ff);
            den_in   = DEN_W'(WINDOW_LEN);
            rem_in   = '0;
            cnt_in   = '0;
         end
         ST_LOAD_S: begin
            rmean_in = num_ff[SAMPLE_BITS-1:0];
            num_in   = NUM_W'(cal_ff);
            den_in   = DEN_W'(num_ff[SAMPLE_BITS-1:0]);
            rem_in   = '0;
            cnt_in   = '0;
         end
         ST_LOAD_M: begin
            // A zero reference mean gives a supply of zero.
            if (rmean_ff == '0) begin
               num_in = '0;
            end
            mcand_in = MCAND_W'(bmean_ff) * MCAND_W'(gain_ff);
            acc_in   = '0;
            cnt_in   = '0;
         end
         ST_DIV_B, ST_DIV_R, ST_DIV_S, ST_DIV_P: begin
            rem_in = div_take ? DEN_W'(div_trial - {1'b0, den_ff}) : DEN_W'(div_trial);
            num_in = {num_ff[NUM_W-2:0], div_take};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_MUL: begin
            acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                     + (num_ff[NUM_W-1] ? PROD_W'(mcand_ff) : PROD_W'(0));
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_SAT: begin
            if (acc_ff[PROD_W-1:SAMPLE_BITS+MV_W] != '0) begin
               mv_in = '1;
            end else begin
               mv_in = acc_ff[SAMPLE_BITS+MV_W-1:SAMPLE_BITS];
            end
         end
         ST_SEL: begin
            // Bands are tested from full down to empty.
            band_in     = 1'b1;
            zero_fix_in = 1'b0;
            if (mv_ff >= level_ff[0]) begin
               band_in = 1'b0;
               pct_in  = PCT_W'(100);
            end else if (mv_ff >= level_ff[1]) begin
               lo = level_ff[1]; hi = level_ff[0]; base_in = PCT_W'(80);
            end else if (mv_ff >= level_ff[2]) begin
               lo = level_ff[2]; hi = level_ff[1]; base_in = PCT_W'(60);
            end else if (mv_ff >= level_ff[3]) begin
               lo = level_ff[3]; hi = level_ff[2]; base_in = PCT_W'(40);
            end else if (mv_ff >= level_ff[4]) begin
               lo = level_ff[4]; hi = level_ff[3]; base_in = PCT_W'(20);
            end else if (mv_ff > level_ff[5]) begin
               lo = level_ff[5]; hi = level_ff[4]; base_in = '0;
               zero_fix_in = 1'b1;
            end else begin
               band_in = 1'b0;
               pct_in  = PCT_W'(1);
            end
            diff   = mv_ff - lo;
            scaled = {diff, 4'b0} + {2'b0, diff, 2'b0} + 21'd0;
            num_in = NUM_W'(scaled);
            den_in = hi - lo;
            rem_in = '0;
            cnt_in = '0;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_full_in  = filled_ff;
               rsp_mv_in    = mv_ff;
               rsp_pct_in   = band_ff ? band_pct : pct_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         filled_ff    <= 1'b0;
         bat_sum_ff   <= '0;
         ref_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            bat_ring_ff[i] <= '0;
            ref_ring_ff[i] <= '0;
         end
         level_ff[0] <= MV_W'(3880);
         level_ff[1] <= MV_W'(3780);
         level_ff[2] <= MV_W'(3690);
         level_ff[3] <= MV_W'(3630);
         level_ff[4] <= MV_W'(3510);
         level_ff[5] <= MV_W'(3200);
         gain_ff     <= GAIN_W'(2);
         cal_ff      <= CAL_W'(4965000);
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         bat_sum_ff   <= bat_sum_in;
         ref_sum_ff   <= ref_sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            bat_ring_ff[slot_ff] <= req_ch.battery_sample;
            ref_ring_ff[slot_ff] <= req_ch.reference_sample;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_LEVEL_FULL:   level_ff[0] <= csr_ch.data[MV_W-1:0];
               CSR_LEVEL_EIGHTY: level_ff[1] <= csr_ch.data[MV_W-1:0];
               CSR_LEVEL_SIXTY:  level_ff[2] <= csr_ch.data[MV_W-1:0];
               CSR_LEVEL_FORTY:  level_ff[3] <= csr_ch.data[MV_W-1:0];
               CSR_LEVEL_TWENTY: level_ff[4] <= csr_ch.data[MV_W-1:0];
               CSR_LEVEL_EMPTY:  level_ff[5] <= csr_ch.data[MV_W-1:0];
               CSR_DIVIDER_GAIN: gain_ff     <= csr_ch.data[GAIN_W-1:0];
               CSR_VREF_CAL:     cal_ff      <= csr_ch.data[CAL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      bmean_ff    <= bmean_in;
      rmean_ff    <= rmean_in;
      mcand_ff    <= mcand_in;
      acc_ff      <= acc_in;
      mv_ff       <= mv_in;
      base_ff     <= base_in;
      band_ff     <= band_in;
      zero_fix_ff <= zero_fix_in;
      pct_ff      <= pct_in;
      rsp_full_ff <= rsp_full_in;
      rsp_mv_ff   <= rsp_mv_in;
      rsp_pct_ff  <= rsp_pct_in;
   end

endmodule

[bench/ble_check.sv]
// Checker that predicts each estimator result and compares it with the block's output.
module ble_check import ble_pkg::*; #(
   parameter int WINDOW_LEN  = 10,
   parameter int SAMPLE_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [SAMPLE_BITS-1:0] req_battery,
   input  logic [SAMPLE_BITS-1:0] req_reference,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_window_full,
   input  logic [MV_W-1:0] rsp_battery_mv,
   input  logic [PCT_W-1:0] rsp_charge_percent,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             window_full;
      logic [MV_W-1:0]  battery_mv;
      logic [PCT_W-1:0] charge_percent;
   } level_type;

   level_type   level_queue[$];
   logic [15:0] thresh_mv[6];
   logic [3:0]  gain;
   logic [23:0] cal_product;
   logic [SAMPLE_BITS-1:0] batt_ring[WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] ref_ring[WINDOW_LEN];
   int          slot;
   logic        filled;

   assign pending_count = level_queue.size();

   // Interpolates inside one band of the discharge table.
   function automatic longint band_pct(longint v, longint lo, longint hi, longint base);
      return base + ((v - lo) * 20) / (hi - lo);
   endfunction

   function automatic longint charge_of(longint v);
      longint r;
      if (v >= thresh_mv[0]) return 100;
      if (v >= thresh_mv[1]) return band_pct(v, thresh_mv[1], thresh_mv[0], 80);
      if (v >= thresh_mv[2]) return band_pct(v, thresh_mv[2], thresh_mv[1], 60);
      if (v >= thresh_mv[3]) return band_pct(v, thresh_mv[3], thresh_mv[2], 40);
      if (v >= thresh_mv[4]) return band_pct(v, thresh_mv[4], thresh_mv[3], 20);
      if (v > thresh_mv[5]) begin
         r = band_pct(v, thresh_mv[5], thresh_mv[4], 0);
         return (r == 0) ? 1 : r;
      end
      return 1;
   endfunction

   function automatic level_type predict_level();
      longint bsum, rsum, bmean, rmean, supply, mv;
      level_type l;
      bsum = 0;
      rsum = 0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         bsum += batt_ring[i];
         rsum += ref_ring[i];
      end
      bmean = bsum / WINDOW_LEN;
      rmean = rsum / WINDOW_LEN;
      supply = (rmean == 0) ? 0 : longint'(cal_product) / rmean;
      mv = (bmean * supply * gain) >> SAMPLE_BITS;
      if (mv > 65535) mv = 65535;
      l.window_full    = filled;
      l.battery_mv     = mv[15:0];
      l.charge_percent = PCT_W'(charge_of(mv));
      return l;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      level_type want;
      if (reset) begin
         thresh_mv   = '{16'd3880, 16'd3780, 16'd3690, 16'd3630, 16'd3510, 16'd3200};
         gain        = 4'd2;
         cal_product = 24'd4965000;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            batt_ring[i] = '0;
            ref_ring[i]  = '0;
         end
         slot   = 0;
         filled = 1'b0;
         error_count = 0;
         level_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEVEL_FULL:   thresh_mv[0] = csr_data[15:0];
               CSR_LEVEL_EIGHTY: thresh_mv[1] = csr_data[15:0];
               CSR_LEVEL_SIXTY:  thresh_mv[2] = csr_data[15:0];
               CSR_LEVEL_FORTY:  thresh_mv[3] = csr_data[15:0];
               CSR_LEVEL_TWENTY: thresh_mv[4] = csr_data[15:0];
               CSR_LEVEL_EMPTY:  thresh_mv[5] = csr_data[15:0];
               CSR_DIVIDER_GAIN: gain = csr_data[3:0];
               CSR_VREF_CAL:     cal_product = csr_data[23:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (level_queue.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = level_queue.pop_front();
               if (rsp_window_full !== want.window_full)
                  report_mismatch("window_full", int'(rsp_window_full),
                                  int'(want.window_full));
               if (rsp_battery_mv !== want.battery_mv)
                  report_mismatch("battery_mv", int'(rsp_battery_mv), int'(want.battery_mv));
               if (rsp_charge_percent !== want.charge_percent)
                  report_mismatch("charge_percent", int'(rsp_charge_percent),
                                  int'(want.charge_percent));
            end
         end
         if (req_valid && req_ready) begin
            batt_ring[slot] = req_battery;
            ref_ring[slot]  = req_reference;
            slot++;
            if (slot >= WINDOW_LEN) begin
               slot   = 0;
               filled = 1'b1;
            end
            level_queue.push_back(predict_level());
         end
      end
   end
endmodule

[bench/tb_top.sv]
// Top of the battery level estimator testbench: stimulus, register phases and verdict.
module tb_top;
   import ble_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_LEN  = 10;
   localparam int SAMPLE_BITS = 12;
   localparam int RANDOM_ITEMS = 1000;
   // Every item may wait out a random gap and a random receiver stall, plus the
   // long hold-off. Taken generously.
   localparam longint CYCLE_LIMIT = 1000000;
   // Register indexes that the block does not decode.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 4'd9;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ble_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch();
   ble_rsp_if rsp_ch();
   ble_csr_if csr_ch();

   int  error_count;
   int  pending_count;
   longint cycle_count = 0;
   bit  idle_free = 1'b0;   // In the last part of the run no side idles.
   bit  hold_rsp  = 1'b0;   // Requests a long receiver hold-off.

   always #6 clock = ~clock;

   battery_level_estimator #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   ble_check #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS)) checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_battery(req_ch.battery_sample), .req_reference(req_ch.reference_sample),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_window_full(rsp_ch.window_full), .rsp_battery_mv(rsp_ch.battery_mv),
      .rsp_charge_percent(rsp_ch.charge_percent),
      .csr_valid(csr_ch.valid), .csr_ready(csr_ch.ready),
      .csr_index(csr_ch.index), .csr_data(csr_ch.data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.battery_sample = '0;
      req_ch.reference_sample = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
   end

   // The cycle counter ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver is ready most of the time, with random stall bursts. A long
   // hold-off is counted in cycles here so the block fills up and stalls.
   initial begin : rsp_side
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            for (n = 0; n < 600; n++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!idle_free && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offers one item and waits until it is taken. Random gaps come before it.
   task automatic send_pair(input logic [SAMPLE_BITS-1:0] batt,
                            input logic [SAMPLE_BITS-1:0] refv);
      if (!idle_free && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.battery_sample <= batt;
      req_ch.reference_sample <= refv;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drops valid and waits until every expected result has come, then lets
   // the block's latency pass so that a register write finds it idle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_table(input int full, input int e80, input int s60, input int f40,
                              input int t20, input int empty);
      write_reg(CSR_LEVEL_FULL, 24'(full));
      write_reg(CSR_LEVEL_EIGHTY, 24'(e80));
      write_reg(CSR_LEVEL_SIXTY, 24'(s60));
      write_reg(CSR_LEVEL_FORTY, 24'(f40));
      write_reg(CSR_LEVEL_TWENTY, 24'(t20));
      write_reg(CSR_LEVEL_EMPTY, 24'(empty));
      @(posedge clock);
   endtask

   // Mostly realistic pairs around a nominal reference so the voltage sweeps
   // through the bands; the rest is full-range noise, including zeros.
   task automatic send_random(input int count);
      logic [SAMPLE_BITS-1:0] b, r;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               b = SAMPLE_BITS'($urandom);
               r = SAMPLE_BITS'($urandom);
            end
            1: begin
               b = SAMPLE_BITS'($urandom);
               r = SAMPLE_BITS'($urandom_range(0, 3));
            end
            default: begin
               b = SAMPLE_BITS'($urandom_range(1500, 2600));
               r = SAMPLE_BITS'($urandom_range(1400, 1700));
            end
         endcase
         send_pair(b, r);
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset settings: zero reference window first,
      // then extremes of both fields so the window fills and wraps.
      send_pair('0, '0);
      send_pair('1, '0);
      send_pair('1, '1);
      send_pair('0, '1);
      for (int i = 0; i < 8; i++) send_pair(SAMPLE_BITS'(2150 + i * 40), 12'd1500);
      send_pair('1, 12'd1);
      send_pair('1, 12'd1);
      drain();

      // Gain of zero, largest gain and calibration extremes: saturation.
      write_reg(CSR_DIVIDER_GAIN, 24'd0);
      send_pair(12'hfff, 12'd1600);
      drain();
      write_reg(CSR_DIVIDER_GAIN, 24'd15);
      write_reg(CSR_VREF_CAL, 24'd12285000);
      send_pair(12'hfff, 12'd5);
      send_pair(12'hfff, 12'd5);
      drain();
      write_reg(CSR_VREF_CAL, 24'd0);
      send_pair(12'h800, 12'h800);
      drain();
      // Out-of-order thresholds and unknown register indexes.
      write_reg(CSR_VREF_CAL, 24'd4965000);
      write_reg(CSR_DIVIDER_GAIN, 24'd2);
      write_table(3000, 3900, 3500, 3700, 3800, 3600);
      write_reg(CSR_SPARE_LOW, 24'hffffff);
      write_reg(CSR_SPARE_HIGH, 24'd1);
      for (int i = 0; i < 4; i++) send_pair(SAMPLE_BITS'(2000 + i * 150), 12'd1550);
      drain();

      // Random phases; the table is rewritten before each and the gain before some.
      write_table(3880, 3780, 3690, 3630, 3510, 3200);
      send_random(250);
      drain();
      write_table(65535, 65535, 65535, 65535, 65535, 65535);
      write_reg(CSR_DIVIDER_GAIN, 24'd1);
      send_random(100);
      drain();
      write_table(0, 0, 0, 0, 0, 0);
      send_random(50);
      drain();
      write_reg(CSR_DIVIDER_GAIN, 24'($urandom_range(1, 15)));
      write_reg(CSR_VREF_CAL, 24'($urandom_range(3000000, 6000000)));
      write_table(4100, 3950, 3800, 3700, 3550, 3300);
      // Long receiver hold-off while items keep coming.
      hold_rsp = 1'b1;
      send_random(200);
      drain();
      write_reg(CSR_DIVIDER_GAIN, 24'd2);
      write_reg(CSR_VREF_CAL, 24'd4965000);
      write_table(3880, 3780, 3690, 3630, 3510, 3200);
      send_random(250);
      // Last part of the run without any idling.
      idle_free = 1'b1;
      send_random(150);
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
